>>> hw/rtl/brx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package brx_pkg;

  localparam int unsigned MAX_ROWS_DEF = 8192;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned IDX_W  = 14;
  localparam int unsigned BIN_W  = 36;
  localparam int unsigned ROW_W  = 13;
  localparam int unsigned CNT_W  = 20;
  localparam int unsigned CFG_W  = 14;

  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned M_TDATA_W = 72;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 14'd8192;
  localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_ROW_COUNT = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_BIN  = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMP  = 2'd1,
    ST_EMIT = 2'd2
  } state_e;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [BIN_W-1:0] first_bin;
    logic [CNT_W-1:0] bin_count;
    logic             bad_bin;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/binned_row_extent_builder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel     Dir  Contents
// s_axis      in   tuser: kind; tdata: entry_index, bin_value
// m_axis      out  tuser: bad_bin; tdata: row_index, first_bin, bin_count
// APB         in   row_count at byte address 0
//
// A load or end item is handled in the idle state; a bin steps the forward
// search over the table one entry at a time, as the row start table memory
// has one read port (one read, one compare per cycle).
// An item that yields a result passes it through the emit state to the output
// register; the input stalls while that register is full and not taken.
// Reset clears the run state and returns row_count to 8192; the table is not
// cleared.

module binned_row_extent_builder #(
  parameter int unsigned MAX_ROWS = brx_pkg::MAX_ROWS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,

  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [13:0] entry_index, [49:14] bin_value, [55:50] zero
  input  wire logic [brx_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] kind
  input  wire logic [brx_pkg::KIND_W-1:0]      s_axis_tuser,

  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [12:0] row_index, [48:13] first_bin, [68:49] bin_count, [71:69] zero
  output logic      [brx_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] bad_bin
  output logic      [0:0]                      m_axis_tuser,

  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [brx_pkg::APB_AW-1:0]      paddr,
  input  wire logic [brx_pkg::APB_DW-1:0]      pwdata,
  output logic      [brx_pkg::APB_DW-1:0]      prdata,
  output logic                                 pready
);

  logic [brx_pkg::CFG_W-1:0] row_count_q;
  logic [brx_pkg::IDX_W-1:0] last;
  logic                      cfg_wr;
  logic [0:0]                reg_sel;

  logic                      res_valid;
  logic                      res_ready;
  brx_pkg::result_t          res;

  logic                      m_valid_q;
  brx_pkg::result_t          m_data_q;

  // APB register
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = (reg_sel == brx_pkg::REG_ROW_COUNT) ? 32'(row_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= brx_pkg::ROW_COUNT_RST;
    end else if (cfg_wr && (reg_sel == brx_pkg::REG_ROW_COUNT)) begin
      row_count_q <= pwdata[brx_pkg::CFG_W-1:0];
    end
  end

  // clamp the searched range to the table depth
  assign last = (32'(row_count_q) > 32'(MAX_ROWS)) ? brx_pkg::IDX_W'(MAX_ROWS) : row_count_q;

  brx_search #(
    .MAX_ROWS (MAX_ROWS)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .in_idx_i    (s_axis_tdata[13:0]),
    .in_bin_i    (s_axis_tdata[49:14]),
    .last_i      (last),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_data_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_data_q.bin_count, m_data_q.first_bin, m_data_q.row_index};
  assign m_axis_tuser  = m_data_q.bad_bin;

  a_bad_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_data_q.bad_bin |-> (m_data_q.bin_count == '0) && (m_data_q.row_index == '0))
    else $error("bad bin result carries a row or a count");

  a_run_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_data_q.bad_bin |-> (m_data_q.bin_count != '0))
    else $error("reported run is empty");

  a_no_take_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !s_axis_tready)
    else $error("input taken while a result is pending");

  a_cfg_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (reg_sel == brx_pkg::REG_ROW_COUNT) |=>
      (row_count_q == $past(pwdata[brx_pkg::CFG_W-1:0])))
    else $error("row_count write lost");

endmodule

`default_nettype wire

>>> hw/rtl/brx_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module brx_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 8193
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/brx_search.sv
`timescale 1ns / 1ps
`default_nettype none

module brx_search #(
  parameter int unsigned MAX_ROWS = brx_pkg::MAX_ROWS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [brx_pkg::KIND_W-1:0]  in_kind_i,
  input  wire logic [brx_pkg::IDX_W-1:0]   in_idx_i,
  input  wire logic [brx_pkg::BIN_W-1:0]   in_bin_i,
  input  wire logic [brx_pkg::IDX_W-1:0]   last_i,
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output brx_pkg::result_t                 res_o
);

  localparam int unsigned DEPTH = MAX_ROWS + 1;
  localparam int unsigned AW    = $clog2(DEPTH);

  brx_pkg::state_e state_q, state_d;

  logic [brx_pkg::IDX_W-1:0] search_row_q, search_row_d;
  logic [brx_pkg::IDX_W-1:0] pos_q, pos_d;
  logic [brx_pkg::BIN_W-1:0] bin_q, bin_d;
  logic                      run_open_q, run_open_d;
  logic [brx_pkg::ROW_W-1:0] run_row_q, run_row_d;
  logic [brx_pkg::BIN_W-1:0] run_first_q, run_first_d;
  logic [brx_pkg::CNT_W-1:0] run_len_q, run_len_d;
  brx_pkg::result_t          res_q, res_d;

  logic                      accept;
  logic                      mem_we;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic [brx_pkg::BIN_W-1:0] mem_rdata;
  logic [brx_pkg::IDX_W-1:0] pos_inc;
  logic [brx_pkg::IDX_W-1:0] pos_dec;
  logic [brx_pkg::ROW_W-1:0] hit_row;
  logic                      hit;
  brx_pkg::result_t          bad_res;

  assign in_ready_o  = (state_q == brx_pkg::ST_IDLE);
  assign res_valid_o = (state_q == brx_pkg::ST_EMIT);
  assign res_o       = res_q;
  assign accept      = in_valid_i & in_ready_o;

  assign pos_inc = pos_q + 14'd1;
  assign pos_dec = pos_q - 14'd1;
  assign hit_row = pos_dec[brx_pkg::ROW_W-1:0];
  assign hit     = mem_rdata > bin_q;

  // loads write only from idle, reads follow later: no overlap on an entry
  assign mem_we = accept && (in_kind_i == brx_pkg::KIND_LOAD) &&
                  (32'(in_idx_i) <= 32'(MAX_ROWS));
  assign mem_raddr = (state_q == brx_pkg::ST_IDLE) ? AW'(search_row_q) : AW'(pos_inc);

  brx_ram #(
    .WIDTH (brx_pkg::BIN_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(in_idx_i)),
    .wdata_i (in_bin_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    bad_res           = '0;
    bad_res.first_bin = bin_q;
    bad_res.bad_bin   = 1'b1;
  end

  always_comb begin
    state_d      = state_q;
    search_row_d = search_row_q;
    pos_d        = pos_q;
    bin_d        = bin_q;
    run_open_d   = run_open_q;
    run_row_d    = run_row_q;
    run_first_d  = run_first_q;
    run_len_d    = run_len_q;
    res_d        = res_q;
    mem_re       = 1'b0;

    case (state_q)
      brx_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_kind_i)
            brx_pkg::KIND_BIN: begin
              bin_d = in_bin_i;
              if (search_row_q > last_i) begin
                res_d           = '0;
                res_d.first_bin = in_bin_i;
                res_d.bad_bin   = 1'b1;
                state_d         = brx_pkg::ST_EMIT;
              end else begin
                mem_re  = 1'b1;
                pos_d   = search_row_q;
                state_d = brx_pkg::ST_CMP;
              end
            end
            brx_pkg::KIND_END: begin
              search_row_d = '0;
              if (run_open_q) begin
                res_d.row_index = run_row_q;
                res_d.first_bin = run_first_q;
                res_d.bin_count = run_len_q;
                res_d.bad_bin   = 1'b0;
                run_open_d      = 1'b0;
                run_row_d       = '0;
                run_first_d     = '0;
                run_len_d       = '0;
                state_d         = brx_pkg::ST_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      brx_pkg::ST_CMP: begin
        if (hit) begin
          if (pos_q == '0) begin
            res_d   = bad_res;
            state_d = brx_pkg::ST_EMIT;
          end else begin
            search_row_d = pos_q;
            state_d      = brx_pkg::ST_IDLE;
            if (!run_open_q) begin
              run_open_d  = 1'b1;
              run_row_d   = hit_row;
              run_first_d = bin_q;
              run_len_d   = 20'd1;
            end else if (hit_row == run_row_q) begin
              if (run_len_q != brx_pkg::CNT_MAX) begin
                run_len_d = run_len_q + 20'd1;
              end
            end else begin
              res_d.row_index = run_row_q;
              res_d.first_bin = run_first_q;
              res_d.bin_count = run_len_q;
              res_d.bad_bin   = 1'b0;
              run_row_d       = hit_row;
              run_first_d     = bin_q;
              run_len_d       = 20'd1;
              state_d         = brx_pkg::ST_EMIT;
            end
          end
        end else if (pos_q < last_i) begin
          // advance the search one table entry
          pos_d  = pos_inc;
          mem_re = 1'b1;
        end else begin
          res_d   = bad_res;
          state_d = brx_pkg::ST_EMIT;
        end
      end

      brx_pkg::ST_EMIT: begin
        if (res_ready_i) begin
          state_d = brx_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = brx_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= brx_pkg::ST_IDLE;
      search_row_q <= '0;
      pos_q        <= '0;
      run_open_q   <= 1'b0;
      run_row_q    <= '0;
      run_first_q  <= '0;
      run_len_q    <= '0;
    end else begin
      state_q      <= state_d;
      search_row_q <= search_row_d;
      pos_q        <= pos_d;
      run_open_q   <= run_open_d;
      run_row_q    <= run_row_d;
      run_first_q  <= run_first_d;
      run_len_q    <= run_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    res_q <= res_d;
  end

endmodule

`default_nettype wire

>>> verif/binned_row_extent_builder_tb.sv
`timescale 1ns / 1ps

module binned_row_extent_builder_tb;
  import brx_pkg::*;

  localparam int unsigned TABLE_LAST   = MAX_ROWS_DEF;
  localparam longint unsigned SLOT     = 64'd8387000;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  localparam logic [APB_AW-1:0] ADDR_ROW_COUNT = {REG_ROW_COUNT, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNUSED    = {~REG_ROW_COUNT, 2'b00};
  localparam int unsigned PHASES        = 9;
  localparam int unsigned PHASE_ITEMS   = 90;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned STUCK_LIMIT   = 40000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [BIN_W-1:0]  bin;
  } feed_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // [13:0] entry_index, [49:14] bin_value
  logic [KIND_W-1:0]    s_axis_tuser  = '0;  // [1:0] kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // [12:0] row_index, [48:13] first_bin, [68:49] bin_count
  logic [0:0]           m_axis_tuser;        // [0] bad_bin
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [APB_AW-1:0]    paddr   = '0;
  logic [APB_DW-1:0]    pwdata  = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  binned_row_extent_builder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // shadow of the block
  logic [CFG_W-1:0] rows_in_use = ROW_COUNT_RST;
  logic [BIN_W-1:0] shadow_starts [0:TABLE_LAST];
  int unsigned      shadow_seek    = 0;
  logic [ROW_W-1:0] shadow_run_row = '0;
  logic [BIN_W-1:0] shadow_run_bin = '0;
  logic [CNT_W-1:0] shadow_run_len = '0;
  bit               shadow_run_live = 1'b0;
  result_t          expected_runs [$];

  // stimulus side
  logic [BIN_W-1:0] plan_starts [0:TABLE_LAST];
  feed_t            pending_feed [$];
  feed_t            cur_feed;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  int unsigned      hold_requests = 0;
  int unsigned      holds_served  = 0;
  int unsigned      hold_left     = 0;
  int unsigned      error_count   = 0;
  int unsigned      stuck_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic flag_error(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic emit_run(input logic [ROW_W-1:0] row, input logic [BIN_W-1:0] first,
                          input logic [CNT_W-1:0] count, input logic bad);
    result_t r;
    r.row_index = row;
    r.first_bin = first;
    r.bin_count = count;
    r.bad_bin   = bad;
    expected_runs.push_back(r);
  endtask

  task automatic track_extent_item(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                                   input logic [BIN_W-1:0] bin);
    int unsigned last_pos, pos;
    bit hit;
    logic [ROW_W-1:0] row;
    last_pos = (rows_in_use > TABLE_LAST) ? TABLE_LAST : rows_in_use;
    if (kind == KIND_LOAD) begin
      if (idx <= TABLE_LAST) shadow_starts[idx] = bin;
    end else if (kind == KIND_END) begin
      shadow_seek = 0;
      if (shadow_run_live) begin
        emit_run(shadow_run_row, shadow_run_bin, shadow_run_len, 1'b0);
        shadow_run_live = 1'b0;
        shadow_run_row  = '0;
        shadow_run_bin  = '0;
        shadow_run_len  = '0;
      end
    end else if (kind == KIND_BIN) begin
      hit = 1'b0;
      pos = shadow_seek;
      while (pos <= last_pos && !hit) begin
        if (shadow_starts[pos] > bin) hit = 1'b1;
        else pos++;
      end
      if (!hit || pos == 0) begin
        emit_run('0, bin, '0, 1'b1);
      end else begin
        shadow_seek = pos;
        row = ROW_W'(pos - 1);
        if (!shadow_run_live) begin
          shadow_run_live = 1'b1;
          shadow_run_row  = row;
          shadow_run_bin  = bin;
          shadow_run_len  = 1;
        end else if (row == shadow_run_row) begin
          if (shadow_run_len != CNT_MAX) shadow_run_len++;
        end else begin
          emit_run(shadow_run_row, shadow_run_bin, shadow_run_len, 1'b0);
          shadow_run_row = row;
          shadow_run_bin = bin;
          shadow_run_len = 1;
        end
      end
    end
  endtask

  // sender: when the bus is free, present the next pending item unless a random idle is drawn
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        track_extent_item(cur_feed.kind, cur_feed.idx, cur_feed.bin);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_feed.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          cur_feed = pending_feed.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, cur_feed.bin, cur_feed.idx};
          s_axis_tuser  <= cur_feed.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each transaction against the oldest expected run
  always @(posedge clk_i) begin : rx_side
    result_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.row_index = m_axis_tdata[12:0];
        got.first_bin = m_axis_tdata[48:13];
        got.bin_count = m_axis_tdata[68:49];
        got.bad_bin   = m_axis_tuser[0];
        if (expected_runs.size() == 0) begin
          flag_error("unexpected result", 64'(got), '0);
        end else begin
          want = expected_runs.pop_front();
          if (got.row_index !== want.row_index)
            flag_error("row_index", 64'(got.row_index), 64'(want.row_index));
          if (got.first_bin !== want.first_bin)
            flag_error("first_bin", 64'(got.first_bin), 64'(want.first_bin));
          if (got.bin_count !== want.bin_count)
            flag_error("bin_count", 64'(got.bin_count), 64'(want.bin_count));
          if (got.bad_bin !== want.bad_bin)
            flag_error("bad_bin", 64'(got.bad_bin), 64'(want.bad_bin));
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("binned_row_extent_builder_tb: errors");
      $finish;
    end
  end

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == REG_ROW_COUNT) rows_in_use = data[CFG_W-1:0];
  endtask

  task automatic apb_check_row_count();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_ROW_COUNT;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== APB_DW'(rows_in_use))
      flag_error("row_count readback", 64'(prdata), 64'(rows_in_use));
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [BIN_W-1:0] rand36();
    logic [3:0] top;
    top = 4'($urandom);
    return {top, 32'($urandom)};
  endfunction

  task automatic offer(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                       input logic [BIN_W-1:0] bin);
    feed_t f;
    f.kind = kind;
    f.idx  = idx;
    f.bin  = bin;
    pending_feed.push_back(f);
  endtask

  function automatic logic [BIN_W-1:0] slot_value(input int unsigned pos);
    return BIN_W'(longint'(pos) * SLOT + $urandom_range(32'(SLOT - 1), 1));
  endfunction

  function automatic logic [BIN_W-1:0] pick_in_row(input int unsigned row,
                                                   input logic [BIN_W-1:0] not_below);
    logic [BIN_W-1:0] lo, hi;
    int unsigned span;
    lo = (plan_starts[row] > not_below) ? plan_starts[row] : not_below;
    hi = plan_starts[row + 1] - 1;
    if (lo > hi) lo = hi;
    span = 32'(hi - lo);
    return lo + $urandom_range(span >> 3, 0);
  endfunction

  function automatic logic [BIN_W-1:0] beyond_last(input int unsigned eff);
    longint unsigned lo, span;
    lo   = longint'(plan_starts[eff]) + 1;
    span = 64'hF_FFFF_FFFF - lo + 1;
    return BIN_W'(lo + (longint'(rand36()) % span));
  endfunction

  task automatic queue_table_load();
    for (int unsigned p = 0; p <= TABLE_LAST; p++) begin
      plan_starts[p] = slot_value(p);
      offer(KIND_LOAD, IDX_W'(p), plan_starts[p]);
      if (p % 1000 == 999) offer(KIND_UNUSED, IDX_W'($urandom), rand36());
    end
  endtask

  task automatic queue_directed();
    offer(KIND_BIN, '0, '0);                                   // below the first start
    offer(KIND_BIN, '0, plan_starts[0]);                       // opens row 0
    offer(KIND_BIN, '1, plan_starts[0] + 1);                   // same row
    offer(KIND_BIN, '0, plan_starts[1]);                       // row change
    offer(KIND_BIN, '0, plan_starts[TABLE_LAST - 1] + 5);      // long forward search
    offer(KIND_BIN, '0, {BIN_W{1'b1}});                        // beyond the last start
    offer(KIND_BIN, '0, plan_starts[TABLE_LAST] - 1);          // still the top row
    offer(KIND_END, '0, '0);
    offer(KIND_END, '1, {BIN_W{1'b1}});                        // nothing open
    offer(KIND_UNUSED, '1, {BIN_W{1'b1}});
    offer(KIND_LOAD, '1, {BIN_W{1'b1}});                       // outside the table
    plan_starts[TABLE_LAST] = slot_value(TABLE_LAST);
    offer(KIND_LOAD, IDX_W'(TABLE_LAST), plan_starts[TABLE_LAST]);
    offer(KIND_BIN, '1, plan_starts[0]);
    offer(KIND_END, '0, '0);
  endtask

  task automatic queue_random(input int unsigned target);
    int unsigned made, eff, row, next_row, len, k, pick, p;
    logic [BIN_W-1:0] bin, prev;
    made = 0;
    eff = (rows_in_use > TABLE_LAST) ? TABLE_LAST : rows_in_use;
    while (made < target) begin
      if ($urandom_range(99, 0) < 85) begin
        len  = $urandom_range(24, 1);
        row  = 0;
        prev = '0;
        if (eff != 0) begin
          row = $urandom_range(1, 0) ? ($urandom_range(63, 0) % eff) : $urandom_range(eff - 1, 0);
          if ($urandom_range(9, 0) == 0) begin
            offer(KIND_BIN, IDX_W'($urandom), $urandom_range(32'(plan_starts[0] - 1), 0));
            made++;
          end
        end
        for (k = 0; k < len; k++) begin
          pick = $urandom_range(99, 0);
          if (eff == 0 || pick >= 97) begin
            bin = rand36();
          end else if (pick >= 95) begin
            bin = beyond_last(eff);
          end else begin
            next_row = row;
            if (pick >= 88) next_row = row + $urandom_range(300, 4);
            else if (pick >= 58) next_row = row + $urandom_range(3, 1);
            if (next_row >= eff) next_row = eff - 1;
            bin  = pick_in_row(next_row, (next_row == row) ? prev : '0);
            row  = next_row;
            prev = bin;
          end
          offer(KIND_BIN, IDX_W'($urandom), bin);
        end
        offer(KIND_END, IDX_W'($urandom), rand36());
        made += len + 1;
      end else begin
        case ($urandom_range(4, 0))
          0: offer(KIND_UNUSED, IDX_W'($urandom), rand36());
          1: offer(KIND_LOAD, IDX_W'($urandom_range(16383, TABLE_LAST + 1)), rand36());
          2: begin
            p = $urandom_range(TABLE_LAST, 0);
            plan_starts[p] = slot_value(p);
            offer(KIND_LOAD, IDX_W'(p), plan_starts[p]);
            made++;
          end
          3: begin
            offer(KIND_END, IDX_W'($urandom), rand36());
            made++;
          end
          default: begin
            offer(KIND_BIN, IDX_W'($urandom), rand36());
            offer(KIND_END, IDX_W'($urandom), rand36());
            made += 2;
          end
        endcase
      end
    end
  endtask

  // close any run and leave the search at the table head
  task automatic queue_closing();
    offer(KIND_END, '0, '0);
    offer(KIND_BIN, '0, '0);
    offer(KIND_END, '0, '0);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_feed.size() != 0 || s_axis_tvalid || expected_runs.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : scenario
    logic [CFG_W-1:0] setting;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 20;
        recv_idle_pct = 75;
      end else if (ph < 6) begin
        send_idle_pct = 75;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0:       setting = CFG_W'(TABLE_LAST);
        1:       setting = 14'd1;
        2:       setting = '1;
        3:       setting = '0;
        4:       setting = CFG_W'(TABLE_LAST - 1);
        5:       setting = 14'd2;
        6:       setting = CFG_W'($urandom_range(300, 3));
        7:       setting = CFG_W'($urandom_range(TABLE_LAST - 2, 301));
        default: setting = CFG_W'(TABLE_LAST);
      endcase
      apb_write(ADDR_ROW_COUNT, {18'($urandom), setting});
      apb_write(ADDR_UNUSED, $urandom);
      apb_check_row_count();
      @(negedge clk_i);
      if (ph == 0) begin
        queue_table_load();
        queue_directed();
      end
      queue_random(PHASE_ITEMS);
      wait_drained();
      queue_random(PHASE_ITEMS);
      queue_closing();
      // stall the result side while items keep coming
      if (ph == PHASES - 1) hold_requests <= hold_requests + 1;
      wait_drained();
    end
    if (error_count == 0)
      $display("binned_row_extent_builder_tb: clean");
    else
      $display("binned_row_extent_builder_tb: errors");
    $finish;
  end

endmodule

>>> binned_row_extent_builder.f
hw/rtl/brx_pkg.sv
hw/rtl/brx_ram.sv
hw/rtl/brx_search.sv
hw/rtl/binned_row_extent_builder.sv
verif/binned_row_extent_builder_tb.sv
